[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[rtl/core/lss_pkg.sv]
// ----------------------------------------------------------------------------
// LIFO stack package
// Command codes and the command and result transfer types of the stack.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Command codes; the remaining codes are treated as no operation.
    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_REVERSE = 3'd3;
    localparam logic [2:0] CMD_SORT    = 3'd4;

    // One command transfer.
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] push_value;
    } command_t;

    // One result transfer.
    typedef struct packed {
        logic signed [31:0] top_value;
        logic               is_empty;
        logic [6:0]         entry_count;
        logic               push_rejected;
    } result_t;

endpackage

[rtl/core/lss_ram.sv]
// ----------------------------------------------------------------------------
// Stack entry memory
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_WIDTH-1:0]      wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_WIDTH-1:0]      rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with write-through forwarding for a same-address access.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lifo_stack_sort_reverse_top.sv]
// ----------------------------------------------------------------------------
// LIFO stack with sort and reverse
// Bounded stack of signed values held in a single-port-read memory.
// ----------------------------------------------------------------------------
//  Channel   Signals                 Transfer
//  command   start, busy, command    at a rising edge with start high, busy low
//  result    done, result            one cycle wide, at the edge ending it
//
// Push, pop, clear and unused codes give their result in the next cycle, and
// a new command is taken in that same result cycle: one command per cycle.
// Reverse holds busy while it reads and rewrites each swapped pair; sort holds
// it while it fetches each key and moves smaller entries up; the result follows.
// Reset clears state, count and reject flag; the entry memory has no clearing pass.
// The receiver cannot stall; busy is high only during reverse and sort.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_sort_reverse_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lss_pkg::command_t command,
    output logic              done,
    output lss_pkg::result_t  result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_RESP      = 8'b0000_0010,
        ST_REV_HI    = 8'b0000_0100,
        ST_REV_WR    = 8'b0000_1000,
        ST_REV_WR2   = 8'b0001_0000,
        ST_SRT_KEY   = 8'b0010_0000,
        ST_SRT_CMP   = 8'b0100_0000,
        ST_SRT_PLACE = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  rej_reg, rej_next;
    logic [CNT_W-1:0]      a_reg, a_next;
    logic [CNT_W-1:0]      b_reg, b_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [CNT_W-1:0]      top_idx;
    logic [DATA_WIDTH-1:0] push_word;
    logic                  accept;
    logic                  key_above;

    lss_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A new command is taken when idle or while the previous result is shown.
    assign busy      = !((state_reg == ST_IDLE) || (state_reg == ST_RESP));
    assign accept    = start && !busy;
    assign push_word = DATA_WIDTH'(command.push_value);
    assign key_above = $signed(mem_rdata) < $signed(key_reg);
    assign top_idx   = count_next - CNT_ONE;

    // Command sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rej_next   = rej_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        key_next   = key_reg;
        tmp_next   = tmp_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;

        case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                if (accept)
                begin
                    rej_next   = 1'b0;
                    state_next = ST_RESP;
                    case (command.cmd)
                        lss_pkg::CMD_PUSH:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[ADDR_W-1:0];
                                mem_wdata  = push_word;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        lss_pkg::CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        lss_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        lss_pkg::CMD_REVERSE:
                        begin
                            if (count_reg >= CNT_TWO)
                            begin
                                a_next     = '0;
                                b_next     = count_reg - CNT_ONE;
                                state_next = ST_REV_HI;
                            end
                        end
                        lss_pkg::CMD_SORT:
                        begin
                            if (count_reg >= CNT_TWO)
                            begin
                                a_next     = CNT_ONE;
                                state_next = ST_SRT_KEY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    // Start of the first pass of a reordering command.
                    if (state_next == ST_REV_HI)
                    begin
                        mem_raddr = '0;
                    end
                    else if (state_next == ST_SRT_KEY)
                    begin
                        mem_raddr = CNT_ONE[ADDR_W-1:0];
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            // Reverse: lower entry arrives, fetch the upper one.
            ST_REV_HI:
            begin
                tmp_next   = mem_rdata;
                mem_raddr  = b_reg[ADDR_W-1:0];
                state_next = ST_REV_WR;
            end
            ST_REV_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = a_reg[ADDR_W-1:0];
                mem_wdata  = mem_rdata;
                state_next = ST_REV_WR2;
            end
            ST_REV_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg[ADDR_W-1:0];
                mem_wdata = tmp_reg;
                a_next    = a_reg + CNT_ONE;
                b_next    = b_reg - CNT_ONE;
                if (a_next < b_next)
                begin
                    mem_raddr  = a_next[ADDR_W-1:0];
                    state_next = ST_REV_HI;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            // Sort: the key arrives, start comparing below it.
            ST_SRT_KEY:
            begin
                key_next   = mem_rdata;
                b_next     = a_reg;
                mem_raddr  = ADDR_W'(a_reg - CNT_ONE);
                state_next = ST_SRT_CMP;
            end
            ST_SRT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg[ADDR_W-1:0];
                if (key_above)
                begin
                    // The entry below is smaller than the key: move it up.
                    mem_wdata = mem_rdata;
                    b_next    = b_reg - CNT_ONE;
                    if (b_next == '0)
                    begin
                        state_next = ST_SRT_PLACE;
                    end
                    else
                    begin
                        mem_raddr = ADDR_W'(b_next - CNT_ONE);
                    end
                end
                else
                begin
                    mem_wdata = key_reg;
                    a_next    = a_reg + CNT_ONE;
                    if (a_next < count_reg)
                    begin
                        mem_raddr  = a_next[ADDR_W-1:0];
                        state_next = ST_SRT_KEY;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SRT_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = key_reg;
                a_next    = a_reg + CNT_ONE;
                if (a_next < count_reg)
                begin
                    mem_raddr  = a_next[ADDR_W-1:0];
                    state_next = ST_SRT_KEY;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Every result cycle is preceded by a read of the new top entry.
        if ((state_next == ST_RESP) && (state_reg != ST_SRT_KEY))
        begin
            mem_raddr = top_idx[ADDR_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rej_reg   <= rej_next;
        end
    end

    // Working registers of the reordering passes.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        key_reg <= key_next;
        tmp_reg <= tmp_next;
    end

    // Result transfer.
    assign done                 = (state_reg == ST_RESP);
    assign result.top_value     = (count_reg == '0) ? 32'sd0 : 32'($signed(mem_rdata));
    assign result.is_empty      = (count_reg == '0);
    assign result.entry_count   = 7'(count_reg);
    assign result.push_rejected = rej_reg;

    // Checks.
    `ASSERT_CLK(a_count_bound, count_reg <= CNT_FULL, "entry count above depth")
    `ASSERT_CLK(a_reject_full, !(done && result.push_rejected) || (count_reg == CNT_FULL),
        "push rejected while not full")
    `ASSERT_NEXT(a_push_count, accept && (command.cmd == lss_pkg::CMD_PUSH) &&
        (count_reg != CNT_FULL), count_reg == $past(count_reg) + CNT_ONE,
        "accepted push did not raise the count")
    `ASSERT_NEXT(a_short_done, accept && ((command.cmd == lss_pkg::CMD_PUSH) ||
        (command.cmd == lss_pkg::CMD_POP) || (command.cmd == lss_pkg::CMD_CLEAR)),
        done, "short command gave no result in the next cycle")
    `ASSERT_NEXT(a_reorder_count, busy, count_reg == $past(count_reg),
        "count changed during a reordering pass")

endmodule
